// ===== src/snils_pkg.sv =====
// shared types, constants and the control value function of the check digit validator
`default_nettype none
package snils_pkg;

	localparam int unsigned DigitW   = 4;
	localparam int unsigned CountW   = 4;
	localparam int unsigned SumW     = 9;
	localparam int unsigned RunW     = 2;
	localparam int unsigned CtrlW    = 7;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 16;

	localparam logic [DigitW-1:0] DigitMax    = 4'd9;
	localparam logic [CountW-1:0] NumDigits   = 4'd9;
	localparam logic [CountW-1:0] RecordLen   = 4'd11;
	localparam logic [CountW-1:0] CountMax    = 4'd15;
	localparam logic [RunW-1:0]   RunLimit    = 2'd3;
	localparam logic [SumW-1:0]   Modulus     = 9'd101;
	localparam logic [SumW-1:0]   Hundred     = 9'd100;

	typedef enum logic [StatusW-1:0] {
		ST_VALID      = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_REPEAT     = 2'd2,
		ST_MISMATCH   = 2'd3
	} status_t;

	// record summary after the closing digit has been folded in
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [SumW-1:0]   sum;
		logic              repeat_seen;
		logic [CtrlW-1:0]  ctrl;
	} rec_t;

	// control value from the weighted sum, sum is at most 405
	function automatic logic [CtrlW-1:0] expected_from_sum(input logic [SumW-1:0] s);
		logic [SumW-1:0] r;
		begin
			if (s >= 9'd404) begin
				r = s - 9'd404;
			end else if (s >= 9'd303) begin
				r = s - 9'd303;
			end else if (s >= 9'd202) begin
				r = s - 9'd202;
			end else if (s >= Modulus) begin
				r = s - Modulus;
			end else begin
				r = s;
			end
			if (r >= Hundred) begin
				r = '0;
			end
			return r[CtrlW-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/snils_check_digit_validator_core.sv =====
// top level of the insurance number check digit validator
//
// channel  dir  tdata bits                              tlast  tuser
// s_*      in   [3:0] digit, [7:4] zero                 last   -
// m_*      out  [1:0] status, [8:2] expected_check,     -      -
//                [15:9] zero
//
// one digit per cycle while no closing digit waits on a stalled result; a
// digit goes through an input register, then the record state, and for a
// closing digit the result register, are updated when it leaves the input
// register; a closing digit's result is then held until it is taken
// a stalled result holds the input register only when it holds a closing digit
// reset clears the record state and both valid flags
`default_nettype none
module snils_check_digit_validator_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [snils_pkg::InDataW-1:0]      s_tdata,   // digit, pad
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [snils_pkg::OutDataW-1:0]          m_tdata    // status, expected_check, pad
);

	logic                          valid_s1;
	logic [snils_pkg::DigitW-1:0]  digit_s1;
	logic                          last_s1;
	logic                          advance;
	logic                          out_valid_q;
	snils_pkg::status_t            status_q;
	logic [snils_pkg::CtrlW-1:0]   expect_q;
	snils_pkg::rec_t               rec;
	snils_pkg::status_t            status;
	logic [snils_pkg::CtrlW-1:0]   expected_check;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			digit_s1 <= s_tdata[snils_pkg::DigitW-1:0];
			last_s1  <= s_tlast;
		end
	end

	snils_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.close  (last_s1),
		.digit  (digit_s1),
		.rec    (rec)
	);

	snils_eval u_eval (
		.rec            (rec),
		.status         (status),
		.expected_check (expected_check)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status;
			expect_q <= expected_check;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(snils_pkg::OutDataW - snils_pkg::CtrlW - snils_pkg::StatusW){1'b0}},
		expect_q, status_q};

endmodule
`default_nettype wire

// ===== src/snils_accum.sv =====
// record state registers: position count, weighted sum, run tracking and control value
`default_nettype none
module snils_accum (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire logic                             close,
	input  wire logic [snils_pkg::DigitW-1:0]     digit,
	output snils_pkg::rec_t                       rec
);

	logic [snils_pkg::CountW-1:0] count_q, count_d;
	logic [snils_pkg::SumW-1:0]   sum_q, sum_d;
	logic [snils_pkg::DigitW-1:0] prev_q, prev_d;
	logic [snils_pkg::RunW-1:0]   run_q, run_d;
	logic                         rep_q, rep_d;
	logic [snils_pkg::CtrlW-1:0]  ctrl_q, ctrl_d;
	logic [snils_pkg::DigitW-1:0] d;
	logic [snils_pkg::DigitW-1:0] weight;
	logic [7:0]                   prod;
	logic [10:0]                  ctrl_ext;

	always_comb begin
		d        = (digit > snils_pkg::DigitMax) ? snils_pkg::DigitMax : digit;
		weight   = snils_pkg::NumDigits - count_q;
		prod     = {4'd0, weight} * {4'd0, d};
		ctrl_ext = ({4'd0, ctrl_q} * 11'd10) + {7'd0, d};
		count_d  = count_q;
		sum_d    = sum_q;
		prev_d   = prev_q;
		run_d    = run_q;
		rep_d    = rep_q;
		ctrl_d   = ctrl_q;
		if (count_q < snils_pkg::NumDigits) begin
			sum_d = sum_q + {1'b0, prod};
			if (count_q == '0 || d != prev_q) begin
				run_d = 2'd1;
			end else begin
				if (run_q < snils_pkg::RunLimit) begin
					run_d = run_q + 2'd1;
				end
				if (run_d == snils_pkg::RunLimit) begin
					rep_d = 1'b1;
				end
			end
			prev_d = d;
		end else if (count_q < snils_pkg::RecordLen) begin
			ctrl_d = ctrl_ext[snils_pkg::CtrlW-1:0];
		end
		if (count_q < snils_pkg::CountMax) begin
			count_d = count_q + 4'd1;
		end
	end

	assign rec = '{count: count_d, sum: sum_d, repeat_seen: rep_d, ctrl: ctrl_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
			run_q   <= '0;
			rep_q   <= 1'b0;
			ctrl_q  <= '0;
		end else if (step) begin
			if (close) begin
				count_q <= '0;
				sum_q   <= '0;
				prev_q  <= '0;
				run_q   <= '0;
				rep_q   <= 1'b0;
				ctrl_q  <= '0;
			end else begin
				count_q <= count_d;
				sum_q   <= sum_d;
				prev_q  <= prev_d;
				run_q   <= run_d;
				rep_q   <= rep_d;
				ctrl_q  <= ctrl_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/snils_eval.sv =====
// status and expected control value of a closed record
`default_nettype none
module snils_eval (
	input  wire snils_pkg::rec_t              rec,
	output snils_pkg::status_t                status,
	output logic [snils_pkg::CtrlW-1:0]       expected_check
);

	always_comb begin
		expected_check = snils_pkg::expected_from_sum(rec.sum);
		if (rec.count != snils_pkg::RecordLen) begin
			status = snils_pkg::ST_BAD_LENGTH;
		end else if (rec.repeat_seen) begin
			status = snils_pkg::ST_REPEAT;
		end else if (rec.ctrl != expected_check) begin
			status = snils_pkg::ST_MISMATCH;
		end else begin
			status = snils_pkg::ST_VALID;
		end
	end

endmodule
`default_nettype wire

// ===== src/snils_checker.sv =====
// port level checks of the validator core and their bind
`default_nettype none
module snils_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_expect_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8:2] <= 7'd99)
		else $error("expected control value out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0)
		else $error("result padding not zero");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a closing digit transfer");

endmodule

bind snils_check_digit_validator_core snils_checker u_snils_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/tb_snils_check_digit_validator_core.sv =====
// testbench for the insurance number check digit validator: directed, random records checked by scoreboard
`timescale 1ns / 1ps
module tb_snils_check_digit_validator_core;

	typedef struct {
		snils_pkg::status_t            status;
		logic [snils_pkg::CtrlW-1:0]   chk;
	} verdict_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [snils_pkg::InDataW-1:0]     s_tdata;   // digit, pad
	logic                              s_tlast;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [snils_pkg::OutDataW-1:0]    m_tdata;   // status, expected_check, pad

	verdict_t                          verdict_q[$];
	verdict_t                          head;
	logic [snils_pkg::DigitW-1:0]      rec_q[$];
	logic [snils_pkg::DigitW-1:0]      num [9];
	int unsigned                       errors = 0;
	int unsigned                       sent_items;
	int unsigned                       rx_count = 0;
	int unsigned                       rx_seen = 0;
	int unsigned                       rx_stall = 0;
	bit                                calm;

	// record state of the scoreboard
	logic [snils_pkg::CountW-1:0]      pos_cnt;
	logic [snils_pkg::SumW-1:0]        wsum;
	logic [snils_pkg::DigitW-1:0]      prev_digit;
	logic [snils_pkg::RunW-1:0]        run_len;
	logic                              run3_seen;
	logic [snils_pkg::CtrlW-1:0]       ctrl_acc;

	snils_check_digit_validator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [snils_pkg::DigitW-1:0] to_digit(input int unsigned v);
		return v[snils_pkg::DigitW-1:0];
	endfunction

	function automatic logic [snils_pkg::CtrlW-1:0] control_for(input int unsigned s);
		int unsigned r;
		if (s < 100) begin
			r = s;
		end else begin
			r = s % 101;
			if (r == 100) begin
				r = 0;
			end
		end
		return r[snils_pkg::CtrlW-1:0];
	endfunction

	function automatic void clear_record();
		pos_cnt    = '0;
		wsum       = '0;
		prev_digit = '0;
		run_len    = '0;
		run3_seen  = 1'b0;
		ctrl_acc   = '0;
	endfunction

	function automatic void fold_digit(input logic [snils_pkg::DigitW-1:0] raw,
		input logic closes);
		logic [snils_pkg::DigitW-1:0] d;
		verdict_t                     v;
		int                           t;
		d = (raw > snils_pkg::DigitMax) ? snils_pkg::DigitMax : raw;
		if (pos_cnt < snils_pkg::NumDigits) begin
			t = int'(wsum) + (9 - int'(pos_cnt)) * int'(d);
			wsum = t[snils_pkg::SumW-1:0];
			if (pos_cnt == 0 || d != prev_digit) begin
				run_len = 2'd1;
			end else begin
				if (run_len < snils_pkg::RunLimit) begin
					run_len = run_len + 2'd1;
				end
				if (run_len == snils_pkg::RunLimit) begin
					run3_seen = 1'b1;
				end
			end
			prev_digit = d;
		end else if (pos_cnt < snils_pkg::RecordLen) begin
			t = int'(ctrl_acc) * 10 + int'(d);
			ctrl_acc = t[snils_pkg::CtrlW-1:0];
		end
		if (pos_cnt != snils_pkg::CountMax) begin
			pos_cnt = pos_cnt + 4'd1;
		end
		if (closes) begin
			v.chk = control_for(int'(wsum));
			if (pos_cnt != snils_pkg::RecordLen) begin
				v.status = snils_pkg::ST_BAD_LENGTH;
			end else if (run3_seen) begin
				v.status = snils_pkg::ST_REPEAT;
			end else if (ctrl_acc != v.chk) begin
				v.status = snils_pkg::ST_MISMATCH;
			end else begin
				v.status = snils_pkg::ST_VALID;
			end
			verdict_q.push_back(v);
			clear_record();
		end
	endfunction

	// transfer monitor and result checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_record();
		end else begin
			if (m_tvalid && m_tready) begin
				rx_count++;
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, got status %0d check %0d", $time,
						m_tdata[snils_pkg::StatusW-1:0],
						m_tdata[snils_pkg::StatusW +: snils_pkg::CtrlW]);
					errors++;
				end else begin
					head = verdict_q.pop_front();
					if (m_tdata[snils_pkg::StatusW-1:0] !== head.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							head.status, m_tdata[snils_pkg::StatusW-1:0]);
						errors++;
					end
					if (m_tdata[snils_pkg::StatusW +: snils_pkg::CtrlW] !== head.chk) begin
						$display("%0t: expected_check expected %0d actual %0d", $time,
							head.chk, m_tdata[snils_pkg::StatusW +: snils_pkg::CtrlW]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				fold_digit(s_tdata[snils_pkg::DigitW-1:0], s_tlast);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (rx_seen != rx_count) begin
			rx_seen  = rx_count;
			rx_stall = calm ? 0 : $urandom_range(0, 3);
		end
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_digit(input logic [snils_pkg::DigitW-1:0] d, input logic closes);
		int unsigned gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(snils_pkg::InDataW - snils_pkg::DigitW){1'b0}}, d};
		s_tlast  <= closes;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_rec();
		int n;
		n = rec_q.size();
		for (int i = 0; i < n; i++) begin
			send_digit(rec_q[i], i == n - 1);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// nine number digits from num, then two control digits
	task automatic send_number(input bit good);
		int unsigned s;
		int unsigned c;
		s = 0;
		rec_q.delete();
		for (int i = 0; i < 9; i++) begin
			s += (9 - i) * num[i];
			rec_q.push_back(num[i]);
		end
		c = control_for(s);
		if (!good) begin
			c = (c + $urandom_range(1, 99)) % 100;
		end
		rec_q.push_back(to_digit(c / 10));
		rec_q.push_back(to_digit(c % 10));
		send_rec();
	endtask

	task automatic random_number();
		for (int i = 0; i < 9; i++) begin
			num[i] = to_digit($urandom_range(0, 9));
		end
	endtask

	task automatic find_number(input int unsigned target);
		int unsigned s;
		int unsigned rest;
		int unsigned d;
		for (int t = 0; t < 4000; t++) begin
			random_number();
			s = 0;
			for (int i = 0; i < 9; i++) begin
				s += (9 - i) * num[i];
			end
			if (s == target) begin
				return;
			end
		end
		rest = target;
		for (int i = 0; i < 9; i++) begin
			d = rest / (9 - i);
			if (d > 9) begin
				d = 9;
			end
			num[i] = to_digit(d);
			rest -= d * (9 - i);
		end
	endtask

	task automatic test_valid_records();
		num = '{4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5};
		send_number(1'b1);
		num = '{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
		send_number(1'b1);
		send_number(1'b0);
	endtask

	task automatic test_special_sums();
		int unsigned targets [6];
		targets = '{0, 100, 101, 201, 302, 404};
		foreach (targets[i]) begin
			find_number(targets[i]);
			send_number(1'b1);
		end
	endtask

	task automatic test_lengths();
		// too short, single closing digit
		send_digit(4'd7, 1'b1);
		// ten digits
		rec_q = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0};
		send_rec();
		// overlong record past count saturation
		rec_q.delete();
		for (int i = 0; i < 18; i++) begin
			rec_q.push_back(to_digit($urandom_range(0, 15)));
		end
		send_rec();
		// digits above nine clamp to nine
		rec_q = '{4'd15, 4'd10, 4'd3, 4'd12, 4'd1, 4'd14, 4'd0, 4'd11, 4'd2, 4'd13, 4'd8};
		send_rec();
	endtask

	task automatic test_repeat();
		num = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7, 4'd7};
		send_number(1'b1);
		// run of two only, then run across the control digits
		num = '{4'd3, 4'd3, 4'd1, 4'd4, 4'd4, 4'd2, 4'd6, 4'd5, 4'd5};
		send_number(1'b1);
		rec_q = '{4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd5, 4'd5, 4'd5, 4'd5};
		send_rec();
	endtask

	task automatic test_drain_pause();
		for (int k = 0; k < 3; k++) begin
			random_number();
			send_number(k != 1);
			drain();
		end
	endtask

	task automatic test_random_records();
		int unsigned kind;
		int unsigned n;
		int unsigned p;
		while (sent_items < 650) begin
			calm = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				random_number();
				send_number(1'b1);
			end else if (kind < 72) begin
				random_number();
				send_number(1'b0);
			end else if (kind < 82) begin
				random_number();
				p = $urandom_range(0, 6);
				num[p + 1] = num[p];
				num[p + 2] = num[p];
				send_number($urandom_range(0, 3) != 0);
			end else begin
				n = (kind < 92) ? $urandom_range(1, 18) : 11;
				rec_q.delete();
				for (int i = 0; i < n; i++) begin
					rec_q.push_back(to_digit($urandom_range(0, 15)));
				end
				send_rec();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		sent_items = 0;
		calm       = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_valid_records();
		test_special_sums();
		test_lengths();
		test_repeat();
		test_drain_pause();
		test_random_records();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== snils_check_digit_validator_core.f =====
src/snils_pkg.sv
src/snils_accum.sv
src/snils_eval.sv
src/snils_check_digit_validator_core.sv
src/snils_checker.sv
test/tb_snils_check_digit_validator_core.sv
